// File: src/tga_rle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; every other file except tga_rle_if imports this package.
package tga_rle_pkg;

    // Parser phase of the front end
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PACKET,
        PH_COLOR
    } t_phase;

    // Command classes passed from the front end to the back end
    typedef enum logic [1:0] {
        CMD_HDR_OK,
        CMD_HDR_BAD,
        CMD_RUN,
        CMD_RAW
    } t_cmd_kind;

    // Result status codes
    localparam logic [1:0] ST_SPAN     = 2'd0;
    localparam logic [1:0] ST_HDR_OK   = 2'd1;
    localparam logic [1:0] ST_HDR_BAD  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [2:0] HDR_LAST_POS = 3'd5;
    localparam logic [7:0] RUN_FLAG     = 8'd128;
    localparam logic [7:0] RUN_BIAS     = 8'd127;
    localparam logic [7:0] DEPTH_24     = 8'd24;
    localparam logic [7:0] DEPTH_32     = 8'd32;
    localparam logic [7:0] MAX_PACKET   = 8'd128;

    // Command queue depth
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    typedef struct packed {
        t_cmd_kind   kind;
        logic        has_alpha;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  count;    // run length, or pixels left after this one in a raw packet
        logic [15:0] width;
        logic [15:0] height;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: src/tga_rle_if.sv
// Channel interfaces for the TGA run-length pixel decoder: byte input and span output.
// No dependencies.
interface tga_rle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first;

    modport source (output valid, output data_byte, output first, input ready);
    modport sink   (input valid, input data_byte, input first, output ready);
endinterface

interface tga_rle_span_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        has_alpha;
    logic [31:0] start_index;
    logic [7:0]  run_length;
    logic        last;
    logic [15:0] image_width;
    logic [15:0] image_height;

    modport source (output valid, output status, output red, output green, output blue,
                    output alpha, output has_alpha, output start_index, output run_length,
                    output last, output image_width, output image_height, input ready);
    modport sink   (input valid, input status, input red, input green, input blue,
                    input alpha, input has_alpha, input start_index, input run_length,
                    input last, input image_width, input image_height, output ready);
endinterface

// File: src/tga_rle_pixel_decoder.sv
// TGA run-length pixel decoder, 24 and 32 bits per pixel; top level.
// Throughput: one stream word per cycle while the queue is not full, one result
// word per cycle while commands wait and ready does not stall the output; a 4-entry
// command queue decouples the parser from the span accounting and output register.
// Reset: synchronous, active low; clears parser, queue and accounting, output empty.
module tga_rle_pixel_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tga_rle_byte_if.sink   i_byte,
    tga_rle_span_if.source o_span
);
    import tga_rle_pkg::*;

    logic    w_push, w_pop;
    t_cmd    w_cmd, w_head;
    t_q_stat w_qstat;

    tga_rle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_cmd   (w_cmd)
    );

    tga_rle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    tga_rle_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_span  (o_span)
    );

endmodule

// File: src/tga_rle_front.sv
// Front end: accepts stream words, parses header and packet bytes, assembles colours
// and pushes commands into the queue. Depends on tga_rle_pkg and tga_rle_if.
module tga_rle_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tga_rle_byte_if.sink         i_byte,
    input  tga_rle_pkg::t_q_stat i_qstat,
    output logic                 o_push,
    output tga_rle_pkg::t_cmd    o_cmd
);
    import tga_rle_pkg::*;

    t_phase      r_phase, n_phase, w_cur;
    logic [2:0]  r_hpos, w_hpos;
    logic [15:0] r_width, r_height;
    logic [7:0]  r_depth;
    logic        r_four;
    logic [7:0]  r_left, w_left_dec;
    logic        r_is_run;
    logic [1:0]  r_cpos;
    logic [7:0]  r_col0, r_col1, r_col2;
    logic        w_acc, w_bad, w_is32, w_hdr_end, w_col_end;
    logic [7:0]  w_b;

    assign i_byte.ready = !i_qstat.full;
    assign w_acc        = i_byte.valid && i_byte.ready;
    assign w_b          = i_byte.data_byte;

    // A first word restarts the header whatever state the parser is in
    assign w_cur      = i_byte.first ? PH_HEADER : r_phase;
    assign w_hpos     = i_byte.first ? 3'd0 : r_hpos;
    assign w_hdr_end  = w_hpos >= HDR_LAST_POS;
    assign w_is32     = r_depth == DEPTH_32;
    assign w_bad      = (r_width == 16'd0) || (r_height == 16'd0) ||
                        ((r_depth != DEPTH_24) && !w_is32);
    assign w_col_end  = r_cpos == (r_four ? 2'd3 : 2'd2);
    assign w_left_dec = r_left - 8'd1;

    // Next state
    always_comb begin
        n_phase = w_cur;
        unique case (w_cur)
            PH_IDLE:   n_phase = PH_IDLE;
            PH_HEADER: begin
                if (w_hdr_end) begin
                    n_phase = w_bad ? PH_IDLE : PH_PACKET;
                end
            end
            PH_PACKET: n_phase = PH_COLOR;
            PH_COLOR: begin
                if (w_col_end && (r_is_run || (w_left_dec == 8'd0))) begin
                    n_phase = PH_PACKET;
                end
            end
        endcase
    end

    // Outputs: one command at a header end or a completed colour
    always_comb begin
        o_push = 1'b0;
        o_cmd  = '0;
        unique case (w_cur)
            PH_IDLE:   o_push = 1'b0;
            PH_HEADER: begin
                if (w_hdr_end) begin
                    o_push          = w_acc;
                    o_cmd.kind      = w_bad ? CMD_HDR_BAD : CMD_HDR_OK;
                    o_cmd.has_alpha = w_is32;
                    o_cmd.width     = r_width;
                    o_cmd.height    = r_height;
                end
            end
            PH_PACKET: o_push = 1'b0;
            PH_COLOR: begin
                if (w_col_end) begin
                    o_push          = w_acc;
                    o_cmd.kind      = r_is_run ? CMD_RUN : CMD_RAW;
                    o_cmd.has_alpha = r_four;
                    o_cmd.blue      = r_col0;
                    o_cmd.green     = r_col1;
                    o_cmd.red       = r_four ? r_col2 : w_b;
                    o_cmd.alpha     = r_four ? w_b : 8'd0;
                    o_cmd.count     = r_is_run ? r_left : w_left_dec;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_hpos   <= 3'd0;
            r_four   <= 1'b0;
            r_left   <= 8'd0;
            r_is_run <= 1'b0;
            r_cpos   <= 2'd0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            unique case (w_cur)
                PH_IDLE:   r_hpos <= r_hpos;
                PH_HEADER: begin
                    if (w_hdr_end) begin
                        r_hpos <= 3'd0;
                        r_four <= w_is32;
                    end else begin
                        r_hpos <= w_hpos + 3'd1;
                    end
                end
                PH_PACKET: begin
                    r_cpos   <= 2'd0;
                    r_is_run <= w_b >= RUN_FLAG;
                    r_left   <= (w_b >= RUN_FLAG) ? (w_b - RUN_BIAS) : (w_b + 8'd1);
                end
                PH_COLOR: begin
                    if (w_col_end) begin
                        r_cpos <= 2'd0;
                        r_left <= r_is_run ? 8'd0 : w_left_dec;
                    end else begin
                        r_cpos <= r_cpos + 2'd1;
                    end
                end
            endcase
        end
    end

    // Header fields and colour bytes
    always_ff @(posedge i_clk) begin
        if (w_acc && (w_cur == PH_HEADER)) begin
            case (w_hpos)
                3'd0:    r_width[7:0]   <= w_b;
                3'd1:    r_width[15:8]  <= w_b;
                3'd2:    r_height[7:0]  <= w_b;
                3'd3:    r_height[15:8] <= w_b;
                3'd4:    r_depth        <= w_b;
                default: r_depth        <= r_depth;
            endcase
        end
        if (w_acc && (w_cur == PH_COLOR) && !w_col_end) begin
            case (r_cpos)
                2'd0:    r_col0 <= w_b;
                2'd1:    r_col1 <= w_b;
                2'd2:    r_col2 <= w_b;
                default: r_col2 <= r_col2;
            endcase
        end
    end

endmodule

// File: src/tga_rle_queue.sv
// Command queue between the front and back ends: a small register FIFO.
// Depends on tga_rle_pkg.
module tga_rle_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tga_rle_pkg::t_cmd    i_cmd,
    input  logic                 i_pop,
    output tga_rle_pkg::t_cmd    o_head,
    output tga_rle_pkg::t_q_stat o_stat
);
    import tga_rle_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_count;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = r_count == (QAW+1)'(QDEPTH);
    assign o_stat.empty = r_count == '0;

    // Clear the entries so the head never presents an unknown command kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem <= '{default: '0};
        end else if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: src/tga_rle_back.sv
// Back end: executes queued commands, keeps pixel accounting and clipping,
// and holds the output register. Depends on tga_rle_pkg and tga_rle_if.
module tga_rle_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tga_rle_pkg::t_cmd    i_head,
    input  tga_rle_pkg::t_q_stat i_qstat,
    output logic                 o_pop,
    tga_rle_span_if.source       o_span
);
    import tga_rle_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        has_alpha;
        logic [31:0] start_index;
        logic [7:0]  run_length;
        logic        last;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } t_res;

    t_res        r_res, w_res;
    logic        r_valid, w_emit, w_take;
    logic        r_active, n_active;
    logic [31:0] r_done, n_done, r_rem, n_rem, w_area;
    logic [7:0]  w_len;
    logic        w_over, w_last, w_rem_small;

    assign w_take = !i_qstat.empty && (!r_valid || o_span.ready);
    assign o_pop  = w_take;
    assign w_area = {16'd0, i_head.width} * {16'd0, i_head.height};

    assign w_rem_small = r_rem[31:8] == 24'd0;

    // Span length and clipping
    always_comb begin
        if (i_head.kind == CMD_RUN) begin
            w_over = w_rem_small && (i_head.count > r_rem[7:0]);
            w_len  = w_over ? r_rem[7:0] : i_head.count;
            w_last = w_over || (r_rem == {24'd0, i_head.count});
        end else begin
            w_len  = 8'd1;
            w_last = r_rem == 32'd1;
            w_over = w_last && (i_head.count != 8'd0);
        end
    end

    always_comb begin
        w_res    = '0;
        w_emit   = 1'b0;
        n_active = r_active;
        n_done   = r_done;
        n_rem    = r_rem;
        w_res.has_alpha = i_head.has_alpha;
        unique case (i_head.kind) inside
            CMD_HDR_OK: begin
                w_emit             = 1'b1;
                w_res.status       = ST_HDR_OK;
                w_res.image_width  = i_head.width;
                w_res.image_height = i_head.height;
                n_active           = 1'b1;
                n_done             = 32'd0;
                n_rem              = w_area;
            end
            CMD_HDR_BAD: begin
                w_emit             = 1'b1;
                w_res.status       = ST_HDR_BAD;
                w_res.last         = 1'b1;
                w_res.image_width  = i_head.width;
                w_res.image_height = i_head.height;
                n_active           = 1'b0;
            end
            CMD_RUN, CMD_RAW: begin
                // Drop spans while no image is open: complete, clipped, bad header or none yet
                w_emit            = r_active;
                w_res.status      = w_over ? ST_OVERFLOW : ST_SPAN;
                w_res.red         = i_head.red;
                w_res.green       = i_head.green;
                w_res.blue        = i_head.blue;
                w_res.alpha       = i_head.alpha;
                w_res.start_index = r_done;
                w_res.run_length  = w_len;
                w_res.last        = w_last;
                if (r_active) begin
                    n_done   = r_done + {24'd0, w_len};
                    n_rem    = r_rem - {24'd0, w_len};
                    n_active = !w_last;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_active <= 1'b0;
            r_done   <= 32'd0;
            r_rem    <= 32'd0;
        end else begin
            if (w_take) begin
                r_valid  <= w_emit;
                r_active <= n_active;
                r_done   <= n_done;
                r_rem    <= n_rem;
            end else if (o_span.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_emit) begin
            r_res <= w_res;
        end
    end

    assign o_span.valid        = r_valid;
    assign o_span.status       = r_res.status;
    assign o_span.red          = r_res.red;
    assign o_span.green        = r_res.green;
    assign o_span.blue         = r_res.blue;
    assign o_span.alpha        = r_res.alpha;
    assign o_span.has_alpha    = r_res.has_alpha;
    assign o_span.start_index  = r_res.start_index;
    assign o_span.run_length   = r_res.run_length;
    assign o_span.last         = r_res.last;
    assign o_span.image_width  = r_res.image_width;
    assign o_span.image_height = r_res.image_height;

    // An open image always has pixels still missing
    a_active_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_rem != 32'd0))
        else $error("active image with no pixels left");

    // A final span closes the image
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_emit && w_res.last) |=> !r_active)
        else $error("image still open after final word");

    // Span words carry between one and a full packet of pixels
    a_span_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_res.status == ST_SPAN || r_res.status == ST_OVERFLOW)) |->
        ((r_res.run_length != 8'd0) && (r_res.run_length <= MAX_PACKET)))
        else $error("span length out of range");

endmodule
